### rtl/mktf_pkg.sv
// ----------------------------------------------------------------------------
// mktf_pkg
// Shared types, constants and helpers for the k-trade profit tracker.
// ----------------------------------------------------------------------------
package mktf_pkg;

	localparam int MAX_TRADES_LIMIT_DEF = 16;
	localparam int MAX_TRADES_W         = 5;
	localparam int FEE_W                = 16;
	localparam int PRICE_W              = 16;
	localparam int VALUE_W              = 32;
	localparam int PROFIT_W             = 31;
	localparam int CFG_INDEX_W          = 2;
	localparam int CFG_DATA_W           = 16;

	localparam logic [MAX_TRADES_W-1:0] MAX_TRADES_RST = MAX_TRADES_W'(2);
	localparam logic [FEE_W-1:0]        TRADE_FEE_RST  = '0;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_MAX_TRADES = 2'd0,
		CFG_TRADE_FEE  = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic start;
		logic run;
		logic load;
	} mktf_cmd_t;

	typedef struct packed {
		logic last_slot;
	} mktf_sts_t;

	function automatic logic signed [VALUE_W-1:0] sat34(input logic signed [33:0] v);
		logic signed [33:0] hi;
		logic signed [33:0] lo;
		hi = 34'sh0_7FFF_FFFF;
		lo = -34'sh0_8000_0000;
		if (v > hi)
			return 32'sh7FFF_FFFF;
		else if (v < lo)
			return 32'sh8000_0000;
		else
			return v[VALUE_W-1:0];
	endfunction

endpackage

### rtl/mktf_ctrl.sv
// ----------------------------------------------------------------------------
// mktf_ctrl
// Sequencer: takes an item, runs the slot pass, then hands the result to the
// output register.
// ----------------------------------------------------------------------------
module mktf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  mktf_pkg::mktf_sts_t sts,
	output mktf_pkg::mktf_cmd_t cmd
);
	import mktf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_HOLD = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d   = state_q;
		cmd.start = 1'b0;
		cmd.run   = 1'b0;
		cmd.load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.run = 1'b1;
				if (sts.last_slot) begin
					if (out_free) begin
						cmd.load = 1'b1;
						state_d  = ST_IDLE;
					end else begin
						state_d = ST_HOLD;
					end
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

### rtl/mktf_dp.sv
// ----------------------------------------------------------------------------
// mktf_dp
// Datapath: config registers, slot store and the shared add-compare unit,
// one slot per cycle, plus the result and output registers.
// ----------------------------------------------------------------------------
module mktf_dp #(
	parameter int MAX_TRADES_LIMIT = mktf_pkg::MAX_TRADES_LIMIT_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	input  logic [mktf_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [mktf_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [mktf_pkg::PRICE_W-1:0]         price,
	input  logic                                 first_day,
	input  mktf_pkg::mktf_cmd_t                  cmd,
	output mktf_pkg::mktf_sts_t                  sts,
	output logic [mktf_pkg::PROFIT_W-1:0]        best_profit
);
	import mktf_pkg::*;

	localparam int SLOT_W = (MAX_TRADES_LIMIT > 1) ? $clog2(MAX_TRADES_LIMIT) : 1;
	localparam int KW     = $clog2(MAX_TRADES_LIMIT + 1);
	localparam int CW     = (KW > MAX_TRADES_W) ? KW : MAX_TRADES_W;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_TRADES_LIMIT - 1);
	localparam logic [CW-1:0]     K_LIMIT   = CW'(MAX_TRADES_LIMIT);

	logic [MAX_TRADES_W-1:0] max_trades_q;
	logic [FEE_W-1:0]        trade_fee_q;
	logic                    started_q;

	logic signed [VALUE_W-1:0] hold_q [MAX_TRADES_LIMIT];
	logic signed [VALUE_W-1:0] free_q [MAX_TRADES_LIMIT];

	logic [SLOT_W-1:0]         slot_q;
	logic [CW-1:0]             k_q;
	logic                      first_q;
	logic [PRICE_W-1:0]        price_q;
	logic signed [16:0]        pmf_q;
	logic signed [VALUE_W-1:0] prev_free_q;
	logic [PROFIT_W-1:0]       res_q;
	logic [PROFIT_W-1:0]       best_profit_q;

	logic [CW-1:0]             k_ext;
	logic signed [VALUE_W-1:0] hold_rd;
	logic signed [VALUE_W-1:0] free_rd;
	logic signed [VALUE_W-1:0] sell;
	logic signed [VALUE_W-1:0] buy;
	logic signed [VALUE_W-1:0] new_free;
	logic signed [VALUE_W-1:0] new_hold;
	logic                      capture;
	logic [PROFIT_W-1:0]       cap_val;
	logic [PROFIT_W-1:0]       res_now;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_trades_q <= MAX_TRADES_RST;
			trade_fee_q  <= TRADE_FEE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MAX_TRADES: max_trades_q <= cfg_data[MAX_TRADES_W-1:0];
				CFG_TRADE_FEE:  trade_fee_q  <= cfg_data[FEE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign k_ext = CW'(max_trades_q);

	// shared add-compare unit
	assign hold_rd = hold_q[slot_q];
	assign free_rd = free_q[slot_q];
	assign sell = sat34(34'(hold_rd) + 34'(pmf_q));
	assign buy  = sat34(34'(prev_free_q) - $signed({18'd0, price_q}));
	assign new_free = first_q ? '0 : ((sell > free_rd) ? sell : free_rd);
	assign new_hold = first_q ? -$signed({16'd0, price_q}) :
	                            ((buy > hold_rd) ? buy : hold_rd);

	assign sts.last_slot = (slot_q == LAST_SLOT);
	assign capture = cmd.run && (k_q != '0) && ((CW'(slot_q) + CW'(1)) == k_q);
	assign cap_val = new_free[VALUE_W-1] ? '0 : new_free[PROFIT_W-1:0];
	assign res_now = capture ? cap_val : res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			started_q <= 1'b0;
		else if (cmd.start)
			started_q <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			slot_q      <= '0;
			k_q         <= (k_ext > K_LIMIT) ? K_LIMIT : k_ext;
			first_q     <= first_day || !started_q;
			price_q     <= price;
			pmf_q       <= $signed({1'b0, price}) - $signed({1'b0, trade_fee_q});
			prev_free_q <= '0;
			res_q       <= '0;
		end else if (cmd.run) begin
			hold_q[slot_q] <= new_hold;
			free_q[slot_q] <= new_free;
			prev_free_q    <= new_free;
			res_q          <= res_now;
			slot_q         <= slot_q + SLOT_W'(1);
		end
		if (cmd.load)
			best_profit_q <= res_now;
	end

	assign best_profit = best_profit_q;

endmodule

### rtl/max_profit_k_trades_fee.sv
// ----------------------------------------------------------------------------
// max_profit_k_trades_fee
// Flow: an accepted item runs a pass over all MAX_TRADES_LIMIT trade slots on the
// single add-compare unit, one trade slot per cycle; a new item is taken only once
// the result of the last has been loaded into the output register.
// Reset: arst_n clears control, config to defaults and the series flag; the
// first item after reset always opens a new series.
// ----------------------------------------------------------------------------
module max_profit_k_trades_fee #(
	parameter int MAX_TRADES_LIMIT = mktf_pkg::MAX_TRADES_LIMIT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mktf_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [mktf_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [mktf_pkg::PRICE_W-1:0]      price,
	input  logic                              first_day,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [mktf_pkg::PROFIT_W-1:0]     best_profit
);
	import mktf_pkg::*;

	mktf_cmd_t cmd;
	mktf_sts_t sts;

	assign cfg_ready = 1'b1;

	mktf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mktf_dp #(
		.MAX_TRADES_LIMIT (MAX_TRADES_LIMIT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.price       (price),
		.first_day   (first_day),
		.cmd         (cmd),
		.sts         (sts),
		.best_profit (best_profit)
	);

endmodule

### rtl/mktf_checker.sv
// ----------------------------------------------------------------------------
// mktf_checker
// Port-level checks on transfer ordering and timing of the profit tracker.
// ----------------------------------------------------------------------------
module mktf_checker #(
	parameter int MAX_TRADES_LIMIT = mktf_pkg::MAX_TRADES_LIMIT_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [mktf_pkg::PROFIT_W-1:0] best_profit
);
	import mktf_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(best_profit))
		else $error("result changed or dropped while stalled");

	// one item at a time
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted again straight after a transfer");

	// the slot pass still runs at its final slot
	a_pass_length: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##MAX_TRADES_LIMIT !in_ready)
		else $error("slot pass finished early");

	// a new result only appears at the end of a pass
	a_result_after_pass: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result raised without a pass");

endmodule

bind max_profit_k_trades_fee mktf_checker #(
	.MAX_TRADES_LIMIT (MAX_TRADES_LIMIT)
) u_mktf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.best_profit (best_profit)
);
